// ===== hw/rtl/gfpc_pkg.sv =====
package gfpc_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_ADDR_BITS = $clog2(PALETTE_ENTRIES);
   localparam int INDEX_BITS = 8;
   localparam int COLOR_BITS = 24;
   localparam int COORD_BITS = 16;
   localparam int SCREEN_BITS = COORD_BITS + 1;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [1:0] TMODE_NONE = 2'd0;
   localparam logic [1:0] TMODE_BACKGROUND = 2'd1;
   localparam logic [1:0] TMODE_SKIP = 2'd2;
   localparam logic [1:0] TMODE_SKIP_ALT = 2'd3;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic [3:0] PASS_START [4] = '{4'd0, 4'd4, 4'd2, 4'd1};
   localparam logic [3:0] PASS_STEP [4] = '{4'd8, 4'd8, 4'd4, 4'd2};

   typedef enum logic [2:0] {
      REG_FRAME_LEFT = 3'd0,
      REG_FRAME_TOP = 3'd1,
      REG_FRAME_WIDTH = 3'd2,
      REG_FRAME_HEIGHT = 3'd3,
      REG_INTERLACED = 3'd4,
      REG_TRANSPARENCY_MODE = 3'd5,
      REG_TRANSPARENT_KEY = 3'd6,
      REG_BACKGROUND_INDEX = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] frame_left;
      logic [COORD_BITS-1:0] frame_top;
      logic [COORD_BITS-1:0] frame_width;
      logic [COORD_BITS-1:0] frame_height;
      logic interlaced;
      logic [1:0] transparency_mode;
      logic [INDEX_BITS-1:0] transparent_key;
      logic [INDEX_BITS-1:0] background_index;
   } cfg_type;

   typedef struct packed {
      logic [SCREEN_BITS-1:0] screen_column;
      logic [SCREEN_BITS-1:0] screen_row;
      logic frame_done;
   } pos_type;

endpackage

// ===== hw/rtl/gfpc_if.sv =====
interface gfpc_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [7:0] palette_slot;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] pixel_index;

   modport source (
      output valid, operation, palette_slot, red_in, green_in, blue_in, pixel_index,
      input ready
   );
   modport sink (
      input valid, operation, palette_slot, red_in, green_in, blue_in, pixel_index,
      output ready
   );
endinterface

interface gfpc_rsp_if;
   logic valid;
   logic ready;
   logic [16:0] screen_column;
   logic [16:0] screen_row;
   logic [31:0] pixel_word;
   logic write_enable;
   logic frame_done;

   modport source (
      output valid, screen_column, screen_row, pixel_word, write_enable, frame_done,
      input ready
   );
   modport sink (
      input valid, screen_column, screen_row, pixel_word, write_enable, frame_done,
      output ready
   );
endinterface

// ===== hw/rtl/gfpc_ram.sv =====
module gfpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/gfpc_csr.sv =====
module gfpc_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [gfpc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [gfpc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [gfpc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic pready,
   output gfpc_pkg::cfg_type cfg
);

   gfpc_pkg::cfg_type cfg_ff;
   gfpc_pkg::cfg_type cfg_in;
   gfpc_pkg::reg_index_type reg_index;
   logic write_hit;

   assign pready = 1'b1;
   assign reg_index = gfpc_pkg::reg_index_type'(paddr[4:2]);
   assign write_hit = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_hit) begin
         unique case (reg_index)
            gfpc_pkg::REG_FRAME_LEFT: cfg_in.frame_left = pwdata[15:0];
            gfpc_pkg::REG_FRAME_TOP: cfg_in.frame_top = pwdata[15:0];
            gfpc_pkg::REG_FRAME_WIDTH: cfg_in.frame_width = pwdata[15:0];
            gfpc_pkg::REG_FRAME_HEIGHT: cfg_in.frame_height = pwdata[15:0];
            gfpc_pkg::REG_INTERLACED: cfg_in.interlaced = pwdata[0];
            gfpc_pkg::REG_TRANSPARENCY_MODE: cfg_in.transparency_mode = pwdata[1:0];
            gfpc_pkg::REG_TRANSPARENT_KEY: cfg_in.transparent_key = pwdata[7:0];
            gfpc_pkg::REG_BACKGROUND_INDEX: cfg_in.background_index = pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         gfpc_pkg::REG_FRAME_LEFT: prdata = {16'd0, cfg_ff.frame_left};
         gfpc_pkg::REG_FRAME_TOP: prdata = {16'd0, cfg_ff.frame_top};
         gfpc_pkg::REG_FRAME_WIDTH: prdata = {16'd0, cfg_ff.frame_width};
         gfpc_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, cfg_ff.frame_height};
         gfpc_pkg::REG_INTERLACED: prdata = {31'd0, cfg_ff.interlaced};
         gfpc_pkg::REG_TRANSPARENCY_MODE: prdata = {30'd0, cfg_ff.transparency_mode};
         gfpc_pkg::REG_TRANSPARENT_KEY: prdata = {24'd0, cfg_ff.transparent_key};
         gfpc_pkg::REG_BACKGROUND_INDEX: prdata = {24'd0, cfg_ff.background_index};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_left <= '0;
         cfg_ff.frame_top <= '0;
         cfg_ff.frame_width <= 16'd1;
         cfg_ff.frame_height <= 16'd1;
         cfg_ff.interlaced <= 1'b0;
         cfg_ff.transparency_mode <= gfpc_pkg::TMODE_NONE;
         cfg_ff.transparent_key <= '0;
         cfg_ff.background_index <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/gfpc_raster.sv =====
module gfpc_raster (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  gfpc_pkg::cfg_type cfg,
   output gfpc_pkg::pos_type pos
);

   logic [gfpc_pkg::COORD_BITS-1:0] column_ff, column_in;
   logic [gfpc_pkg::COORD_BITS-1:0] stored_row_ff, stored_row_in;
   logic [gfpc_pkg::COORD_BITS-1:0] mapped_row_ff, mapped_row_in;
   logic [1:0] pass_ff, pass_in;

   logic [gfpc_pkg::COORD_BITS:0] column_next;
   logic [gfpc_pkg::COORD_BITS:0] stored_next;
   logic [gfpc_pkg::COORD_BITS:0] stepped_row;
   logic row_end;
   logic frame_end;
   logic pass_found;
   logic [1:0] found_pass;
   logic [3:0] found_start;

   assign column_next = {1'b0, column_ff} + 17'd1;
   assign stored_next = {1'b0, stored_row_ff} + 17'd1;
   assign stepped_row = {1'b0, mapped_row_ff} + 17'(gfpc_pkg::PASS_STEP[pass_ff]);
   assign row_end = column_next >= {1'b0, cfg.frame_width};
   assign frame_end = row_end && (stored_next >= {1'b0, cfg.frame_height});

   always_comb begin
      pass_found = 1'b0;
      found_pass = 2'd0;
      found_start = 4'd0;
      for (int p = 1; p < 4; p++) begin
         if (!pass_found && (2'(p) > pass_ff)
             && ({12'd0, gfpc_pkg::PASS_START[p]} < cfg.frame_height)) begin
            pass_found = 1'b1;
            found_pass = 2'(p);
            found_start = gfpc_pkg::PASS_START[p];
         end
      end
   end

   always_comb begin
      column_in = column_ff;
      stored_row_in = stored_row_ff;
      mapped_row_in = mapped_row_ff;
      pass_in = pass_ff;
      if (advance) begin
         if (frame_end) begin
            column_in = '0;
            stored_row_in = '0;
            mapped_row_in = '0;
            pass_in = '0;
         end else if (row_end) begin
            column_in = '0;
            stored_row_in = stored_next[gfpc_pkg::COORD_BITS-1:0];
            if (!cfg.interlaced) begin
               mapped_row_in = mapped_row_ff + 16'd1;
            end else if (stepped_row < {1'b0, cfg.frame_height}) begin
               mapped_row_in = stepped_row[gfpc_pkg::COORD_BITS-1:0];
            end else if (pass_found) begin
               pass_in = found_pass;
               mapped_row_in = {12'd0, found_start};
            end else begin
               pass_in = '0;
               mapped_row_in = '0;
            end
         end else begin
            column_in = column_next[gfpc_pkg::COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         stored_row_ff <= '0;
         mapped_row_ff <= '0;
         pass_ff <= '0;
      end else begin
         column_ff <= column_in;
         stored_row_ff <= stored_row_in;
         mapped_row_ff <= mapped_row_in;
         pass_ff <= pass_in;
      end
   end

   assign pos.screen_column = {1'b0, cfg.frame_left} + {1'b0, column_ff};
   assign pos.screen_row = {1'b0, cfg.frame_top} + {1'b0, mapped_row_ff};
   assign pos.frame_done = frame_end;

endmodule

// ===== hw/rtl/gif_frame_pixel_compositor.sv =====
// Renders one decoded GIF frame into screen coordinates and packed colors.
// The req channel carries palette write items and pixel items in stored
// raster order. A palette write item loads one entry and yields no result;
// a pixel item yields one rsp item with screen column, screen row, the word
// 0xFF/blue/green/red, a write enable and a frame-done flag.
// Frame geometry, interlace and transparency settings sit in APB registers
// at byte address 4*i; the user must see that they are written only while
// the block is idle; the block does not enforce this. Throughput is one item
// per cycle while the receiver does not stall, set by the single palette RAM
// port pair: a write port for palette items and a read port for pixel items.
// A pixel passes the palette read and raster position stage, then the output
// register; it may follow a write to its palette entry in the next cycle.
// When the receiver stalls, the output register holds its item and one more
// item may still be accepted into the read stage; after that req.ready drops.
// Reset clears the raster counters, the pipeline valid bits and the registers
// to their defaults; the palette is undefined until written.
module gif_frame_pixel_compositor (
   input  logic clock,
   input  logic reset,
   gfpc_req_if.sink req,
   gfpc_rsp_if.source rsp,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [gfpc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [gfpc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [gfpc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic pready
);

   gfpc_pkg::cfg_type cfg;
   gfpc_pkg::pos_type pos;

   logic out_free;
   logic s1_move;
   logic accept;
   logic pixel_accept;
   logic palette_accept;
   logic slot_in_range;
   logic is_key;
   logic skip_mode;
   logic [gfpc_pkg::INDEX_BITS-1:0] read_index;
   logic read_in_range;
   logic [gfpc_pkg::COLOR_BITS-1:0] rd_data;

   logic s1_valid_ff, s1_valid_in;
   gfpc_pkg::pos_type s1_pos_ff;
   logic s1_skip_ff;
   logic s1_blank_ff;

   logic rsp_valid_ff, rsp_valid_in;
   gfpc_pkg::pos_type rsp_pos_ff;
   logic [31:0] rsp_word_ff;
   logic rsp_we_ff;

   gfpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s1_move = s1_valid_ff && out_free;
   assign req.ready = out_free || !s1_valid_ff;
   assign accept = req.valid && req.ready;
   assign pixel_accept = accept && (req.operation == gfpc_pkg::OP_PIXEL);
   assign palette_accept = accept && (req.operation == gfpc_pkg::OP_PALETTE);

   assign slot_in_range = {1'b0, req.palette_slot} < 9'(gfpc_pkg::PALETTE_ENTRIES);
   assign skip_mode = (cfg.transparency_mode == gfpc_pkg::TMODE_SKIP)
                   || (cfg.transparency_mode == gfpc_pkg::TMODE_SKIP_ALT);
   assign is_key = (cfg.transparency_mode != gfpc_pkg::TMODE_NONE)
                && (req.pixel_index == cfg.transparent_key);
   assign read_index = is_key ? cfg.background_index : req.pixel_index;
   assign read_in_range = {1'b0, read_index} < 9'(gfpc_pkg::PALETTE_ENTRIES);

   gfpc_raster u_raster (
      .clock   (clock),
      .reset   (reset),
      .advance (pixel_accept),
      .cfg     (cfg),
      .pos     (pos)
   );

   gfpc_ram #(
      .WIDTH (gfpc_pkg::COLOR_BITS),
      .DEPTH (gfpc_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (palette_accept && slot_in_range),
      .wr_addr (req.palette_slot[gfpc_pkg::PAL_ADDR_BITS-1:0]),
      .wr_data ({req.blue_in, req.green_in, req.red_in}),
      .rd_en   (pixel_accept),
      .rd_addr (read_index[gfpc_pkg::PAL_ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pixel_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_accept) begin
         s1_pos_ff <= pos;
         s1_skip_ff <= is_key && skip_mode;
         s1_blank_ff <= !read_in_range;
      end
      if (s1_move) begin
         rsp_pos_ff <= s1_pos_ff;
         rsp_we_ff <= !s1_skip_ff;
         if (s1_skip_ff) begin
            rsp_word_ff <= '0;
         end else if (s1_blank_ff) begin
            rsp_word_ff <= {gfpc_pkg::ALPHA_OPAQUE, 24'd0};
         end else begin
            rsp_word_ff <= {gfpc_pkg::ALPHA_OPAQUE, rd_data};
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.screen_column = rsp_pos_ff.screen_column;
   assign rsp.screen_row = rsp_pos_ff.screen_row;
   assign rsp.pixel_word = rsp_word_ff;
   assign rsp.write_enable = rsp_we_ff;
   assign rsp.frame_done = rsp_pos_ff.frame_done;

endmodule
